### rtl/core/gray_histogram_mode_and_unique_defines.svh
// Assertion macros for the checker file of the histogram block.
`ifndef GRAY_HISTOGRAM_MODE_AND_UNIQUE_DEFINES_SVH
`define GRAY_HISTOGRAM_MODE_AND_UNIQUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define HGM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define HGM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram check failed");

`endif

### rtl/core/hgm_pkg.sv
`default_nettype none
package hgm_pkg;

  // Histogram geometry
  localparam int PIXEL_BITS = 8;
  localparam int MAX_PIXELS = 16777216;

  // Field widths of the channels
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = PIXEL_BITS;
  localparam int COUNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int UNIQUE_W = PIXEL_BITS + 1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_ADD        = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_REPORT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REPORT     = 2'd2;

  // Control from the sequencer to the scan unit
  typedef struct packed {
    logic clr;
    logic en;
  } scan_ctl_t;

endpackage
`default_nettype wire

### rtl/core/hgm_bin_ram.sv
`default_nettype none
module hgm_bin_ram #(
  parameter int AW = 8,
  parameter int DW = 25
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [(1 << AW)];
  logic [DW-1:0] rd_data_r;

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### rtl/core/hgm_scan_unit.sv
`default_nettype none
module hgm_scan_unit
  import hgm_pkg::*;
#(
  parameter int IW = 8,
  parameter int CW = 25
) (
  input  wire logic      clk,
  input  wire scan_ctl_t ctl,
  input  wire logic [IW-1:0] idx,
  input  wire logic [CW-1:0] cnt,
  output logic      [IW-1:0] best_val,
  output logic      [CW-1:0] best_cnt,
  output logic      [IW:0]   distinct
);

  logic [IW-1:0] best_val_r;
  logic [CW-1:0] best_cnt_r;
  logic [IW:0]   distinct_r;

  // While en is high, compare one bin per cycle against the running best and count nonzero
  // bins; strict greater keeps the smallest value on ties since bins arrive in ascending order
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      best_val_r <= '0;
      best_cnt_r <= '0;
      distinct_r <= '0;
    end else if (ctl.en) begin
      if (cnt != '0) begin
        distinct_r <= distinct_r + 1'b1;
      end
      if (cnt > best_cnt_r) begin
        best_cnt_r <= cnt;
        best_val_r <= idx;
      end
    end
  end

  assign best_val = best_val_r;
  assign best_cnt = best_cnt_r;
  assign distinct = distinct_r;

endmodule
`default_nettype wire

### rtl/core/gray_histogram_mode_and_unique.sv
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   in_action, in_pixel
// out_     output     out_valid / out_ready mode_value, mode_count, unique_count, empty_res
//
// Add pixel: bin read, then saturating write back, on one RAM.
// Report: the scan reads one bin per cycle,
// compares it in the scan unit and writes it back to zero.
// After reset a clearing pass over all 2^PIXEL_BITS bins runs before in_ready rises.
// A stalled result holds in the output register; the next transaction is
// taken meanwhile, and a new report waits at its end for the register to free.
`default_nettype none
module gray_histogram_mode_and_unique
  import hgm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [ACTION_W-1:0] in_action,
  input  wire logic [VALUE_W-1:0]  in_pixel,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [VALUE_W-1:0]  out_mode_value,
  output logic      [COUNT_W-1:0]  out_mode_count,
  output logic      [UNIQUE_W-1:0] out_unique_count,
  output logic                     out_empty_res
);

  localparam int AW = PIXEL_BITS;
  localparam int CW = COUNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ADD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [AW:0]         addr_r, addr_nxt;
  logic [AW-1:0]       idx_r;
  logic [ACTION_W-1:0] act_r;
  logic                rd_vld_r;
  logic [AW-1:0]       rd_idx_r;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] rd_data, wr_data;

  scan_ctl_t     ctl;
  logic [AW-1:0] best_val;
  logic [CW-1:0] best_cnt;
  logic [AW:0]   distinct;
  logic          out_load;
  logic          do_add, do_report;

  logic                out_valid_r;
  logic [VALUE_W-1:0]  mode_value_r;
  logic [COUNT_W-1:0]  mode_count_r;
  logic [UNIQUE_W-1:0] unique_count_r;
  logic                empty_res_r;

  assign in_ready  = (state_r == S_IDLE);
  assign do_add    = (act_r == ACT_ADD) || (act_r == ACT_ADD_REPORT);
  assign do_report = (act_r == ACT_ADD_REPORT) || (act_r == ACT_REPORT);

  hgm_bin_ram #(.AW(AW), .DW(CW)) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  hgm_scan_unit #(.IW(AW), .CW(CW)) u_scan (
    .clk      (clk),
    .ctl      (ctl),
    .idx      (rd_idx_r),
    .cnt      (rd_data),
    .best_val (best_val),
    .best_cnt (best_cnt),
    .distinct (distinct)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    rd_en     = 1'b0;
    rd_addr   = AW'(in_pixel);
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '0;
    ctl       = '0;
    out_load  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        wr_en    = 1'b1;
        wr_addr  = addr_r[AW-1:0];
        addr_nxt = addr_r + 1'b1;
        if (&addr_r[AW-1:0]) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (do_add) begin
          wr_en   = 1'b1;
          wr_data = (rd_data < CW'(MAX_PIXELS)) ? rd_data + 1'b1 : rd_data;
        end
        if (do_report) begin
          ctl.clr   = 1'b1;
          addr_nxt  = '0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        rd_en   = !addr_r[AW];
        rd_addr = addr_r[AW-1:0];
        if (!addr_r[AW]) begin
          addr_nxt = addr_r + 1'b1;
        end
        // clear each bin right after it is read
        wr_en   = rd_vld_r;
        wr_addr = rd_idx_r;
        ctl.en  = rd_vld_r;
        if (addr_r[AW] && !rd_vld_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        addr_nxt  = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      addr_r   <= addr_nxt;
      rd_vld_r <= (state_r == S_SCAN) && !addr_r[AW];
    end
  end

  // Hold the accepted transaction and the scan pipeline index
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      idx_r <= AW'(in_pixel);
      act_r <= in_action;
    end
    rd_idx_r <= addr_r[AW-1:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mode_value_r   <= VALUE_W'(best_val);
      mode_count_r   <= COUNT_W'(best_cnt);
      unique_count_r <= UNIQUE_W'(distinct);
      empty_res_r    <= (distinct == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mode_value   = mode_value_r;
  assign out_mode_count   = mode_count_r;
  assign out_unique_count = unique_count_r;
  assign out_empty_res    = empty_res_r;

endmodule
`default_nettype wire

### rtl/core/hgm_checker.sv
`default_nettype none
`include "gray_histogram_mode_and_unique_defines.svh"
module hgm_checker
  import hgm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [VALUE_W-1:0]  out_mode_value,
  input wire logic [COUNT_W-1:0]  out_mode_count,
  input wire logic [UNIQUE_W-1:0] out_unique_count,
  input wire logic                out_empty_res
);

  // An empty image reports all fields zero
  `HGM_ASSERT_IMPL(a_empty_zero, out_valid && out_empty_res,
    out_mode_count == '0 && out_unique_count == '0 && out_mode_value == '0)

  // A non-empty image has a mode with a nonzero count
  `HGM_ASSERT_IMPL(a_nonempty_count, out_valid && !out_empty_res,
    out_mode_count != '0 && out_unique_count != '0)

  // Each accepted transaction drops in_ready in the next cycle
  `HGM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // A new result appears only at the end of a report, never from idle
  `HGM_ASSERT_NEXT(a_result_from_report, in_ready && !out_valid, !out_valid)

  // A stalled result holds its payload
  `HGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_mode_count) && $stable(out_mode_value))

endmodule

bind gray_histogram_mode_and_unique hgm_checker u_hgm_checker (.*);
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hgm_pkg::*;

  // Code that the block must ignore: no bin update, no report
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int NUM_BINS      = 256;
  localparam int BIN_LIMIT     = 16777216;
  localparam int ITEM_TARGET   = 1850;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 300;

  // Idle percentages per traffic phase: sender busy, receiver busy, no idling
  localparam int SEND_IDLE_PCT [3] = '{10, 53, 0};
  localparam int RECV_IDLE_PCT [3] = '{53, 10, 0};

  typedef struct {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  pixel;
    int                  phase;
    bit                  drain_first;
  } pixel_txn_t;

  typedef struct {
    logic [VALUE_W-1:0]  mode_value;
    logic [COUNT_W-1:0]  mode_count;
    logic [UNIQUE_W-1:0] unique_count;
    logic                empty;
  } image_stats_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [ACTION_W-1:0] in_action = ACT_ADD;
  logic [VALUE_W-1:0]  in_pixel = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [VALUE_W-1:0]  out_mode_value;
  logic [COUNT_W-1:0]  out_mode_count;
  logic [UNIQUE_W-1:0] out_unique_count;
  logic                out_empty_res;

  pixel_txn_t   pending_txns [$];
  image_stats_t expected_stats [$];
  logic [COUNT_W-1:0] bin_tally [NUM_BINS];

  int traffic_phase = 0;
  int counted_items = 0;
  int txns_built = 0;
  int items_taken = 0;
  int pixels_added = 0;
  int reports_seen = 0;
  int empty_seen = 0;
  int max_unique = 0;
  int drain_pauses = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  gray_histogram_mode_and_unique dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mode_value   (out_mode_value),
    .out_mode_count   (out_mode_count),
    .out_unique_count (out_unique_count),
    .out_empty_res    (out_empty_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Count one pixel in its bin, saturating at the bin limit
  function automatic void tally_pixel(logic [VALUE_W-1:0] px);
    if (bin_tally[px] < BIN_LIMIT) bin_tally[px] = bin_tally[px] + 1'b1;
  endfunction

  // Scan bins in ascending order for mode and distinct count, then clear them
  function automatic image_stats_t close_image();
    image_stats_t s;
    s.mode_value   = '0;
    s.mode_count   = '0;
    s.unique_count = '0;
    for (int b = 0; b < NUM_BINS; b++) begin
      if (bin_tally[b] != '0) s.unique_count = s.unique_count + 1'b1;
      if (bin_tally[b] > s.mode_count) begin
        s.mode_count = bin_tally[b];
        s.mode_value = VALUE_W'(b);
      end
      bin_tally[b] = '0;
    end
    s.empty = (s.unique_count == '0);
    return s;
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Append one transaction; the traffic phase follows the share of real items
  task automatic queue_txn(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] px,
                           bit hold);
    pixel_txn_t t;
    t.action      = act;
    t.pixel       = px;
    t.drain_first = hold;
    t.phase       = (counted_items * 3) / ITEM_TARGET;
    if (t.phase > 2) t.phase = 2;
    pending_txns.push_back(t);
    txns_built++;
    if (act != ACT_UNUSED) counted_items++;
  endtask

  // Drive the next pending transaction; hold valid and payload until accepted
  always @(posedge clk) begin
    pixel_txn_t nxt;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_action <= ACT_ADD;
      in_pixel  <= '0;
    end else if (!in_valid || in_ready) begin
      if (pending_txns.size() != 0 &&
          (!pending_txns[0].drain_first || (!in_valid && expected_stats.size() == 0)) &&
          $urandom_range(99) >= SEND_IDLE_PCT[pending_txns[0].phase]) begin
        nxt = pending_txns.pop_front();
        if (nxt.drain_first) drain_pauses++;
        traffic_phase = nxt.phase;
        in_valid  <= 1'b1;
        in_action <= nxt.action;
        in_pixel  <= nxt.pixel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= RECV_IDLE_PCT[traffic_phase]);
  end

  // Predict on each input transaction, check each result transaction
  always @(posedge clk) begin
    image_stats_t want;
    if (!rst_n) begin
      for (int b = 0; b < NUM_BINS; b++) bin_tally[b] = '0;
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        case (in_action)
          ACT_ADD: begin
            tally_pixel(in_pixel);
            pixels_added++;
          end
          ACT_ADD_REPORT: begin
            tally_pixel(in_pixel);
            pixels_added++;
            expected_stats.push_back(close_image());
          end
          ACT_REPORT: expected_stats.push_back(close_image());
          ACT_UNUSED: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_stats.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: value=%0d count=%0d unique=%0d empty=%0b",
                                  out_mode_value, out_mode_count, out_unique_count,
                                  out_empty_res));
        end else begin
          want = expected_stats.pop_front();
          if (out_mode_value !== want.mode_value)
            flag_mismatch($sformatf("mode_value %0d, want %0d", out_mode_value, want.mode_value));
          if (out_mode_count !== want.mode_count)
            flag_mismatch($sformatf("mode_count %0d, want %0d", out_mode_count, want.mode_count));
          if (out_unique_count !== want.unique_count)
            flag_mismatch($sformatf("unique_count %0d, want %0d", out_unique_count,
                                    want.unique_count));
          if (out_empty_res !== want.empty)
            flag_mismatch($sformatf("empty_res %0b, want %0b", out_empty_res, want.empty));
          reports_seen++;
          if (want.empty) empty_seen++;
          if (want.unique_count > max_unique) max_unique = want.unique_count;
        end
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles, %0d results pending",
               $time, STALL_LIMIT, expected_stats.size());
      $display("gray_histogram_mode_and_unique test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int image_no;
    int kind;
    int npix;
    int pal_size;
    int j;
    int tmp;
    bit sweep;
    bit hold;
    logic [ACTION_W-1:0] close_act;
    logic [VALUE_W-1:0]  px;
    logic [VALUE_W-1:0]  palette [4];
    int order [NUM_BINS];

    // Empty image, then an ignored code that must leave the image empty
    queue_txn(ACT_REPORT, 8'h5A, 1'b0);
    queue_txn(ACT_UNUSED, 8'hAA, 1'b0);
    queue_txn(ACT_REPORT, 8'h55, 1'b0);
    // Tie between the extremes: the smallest value wins
    queue_txn(ACT_ADD, 8'h00, 1'b0);
    queue_txn(ACT_ADD, 8'hFF, 1'b0);
    queue_txn(ACT_ADD, 8'hFF, 1'b0);
    queue_txn(ACT_ADD_REPORT, 8'h00, 1'b0);
    // Single pixel image at the top value
    queue_txn(ACT_ADD_REPORT, 8'hFF, 1'b0);
    // Tie with an ignored code in the middle
    queue_txn(ACT_ADD, 8'd7, 1'b0);
    queue_txn(ACT_ADD, 8'd200, 1'b0);
    queue_txn(ACT_ADD, 8'd200, 1'b0);
    queue_txn(ACT_UNUSED, 8'd7, 1'b0);
    queue_txn(ACT_ADD_REPORT, 8'd7, 1'b0);
    // Report-only whose pixel must not be counted
    queue_txn(ACT_ADD, 8'd128, 1'b0);
    queue_txn(ACT_ADD, 8'd128, 1'b0);
    queue_txn(ACT_UNUSED, 8'd128, 1'b0);
    queue_txn(ACT_REPORT, 8'hFF, 1'b0);
    // Back-to-back reports: the second sees a cleared histogram
    queue_txn(ACT_ADD_REPORT, 8'h81, 1'b0);
    queue_txn(ACT_REPORT, 8'h81, 1'b0);
    queue_txn(ACT_REPORT, 8'h00, 1'b0);

    // Random images: mostly well-formed with a report at the end, some noise
    image_no = 0;
    while (counted_items < ITEM_TARGET) begin
      kind  = $urandom_range(99);
      sweep = (image_no % 40 == 7);
      hold  = (image_no % 25 == 3);
      pal_size = $urandom_range(1, 4);
      for (int p = 0; p < 4; p++) palette[p] = VALUE_W'($urandom);
      if (sweep) begin
        // Every gray value once in shuffled order, plus up to four more pixels
        for (int v = 0; v < NUM_BINS; v++) order[v] = v;
        for (int v = NUM_BINS - 1; v > 0; v--) begin
          j = $urandom_range(v);
          tmp = order[v];
          order[v] = order[j];
          order[j] = tmp;
        end
        npix = NUM_BINS + $urandom_range(4);
      end else if (kind < 3) begin
        pal_size = 1;
        npix = $urandom_range(100, 300);
      end else if (kind < 13) begin
        npix = 0;
      end else if (kind < 63) begin
        npix = $urandom_range(1, 40);
      end else begin
        npix = $urandom_range(1, 30);
      end
      close_act = (npix != 0 && $urandom_range(1) == 1) ? ACT_ADD_REPORT : ACT_REPORT;
      for (int k = 0; k < npix; k++) begin
        if (sweep && k < NUM_BINS) px = VALUE_W'(order[k]);
        else if (kind < 63) px = palette[$urandom_range(pal_size - 1)];
        else px = VALUE_W'($urandom);
        queue_txn((k == npix - 1 && close_act == ACT_ADD_REPORT) ? ACT_ADD_REPORT : ACT_ADD,
                  px, hold);
        hold = 1'b0;
        if ($urandom_range(99) < 4) queue_txn(ACT_UNUSED, VALUE_W'($urandom), 1'b0);
      end
      if (close_act == ACT_REPORT) queue_txn(ACT_REPORT, VALUE_W'($urandom), hold);
      image_no++;
    end

    // Hold reset, then release it for the rest of the run
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction and result, then watch for stray results
    while (items_taken != txns_built || expected_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d transactions (%0d pixels) over %0d images; %0d reports checked, %0d empty.",
             items_taken, pixels_added, image_no + 9, reports_seen, empty_seen);
    $display("Widest image held %0d distinct values; %0d drain pauses; %0d mismatches.",
             max_unique, drain_pauses, mismatches);
    if (mismatches == 0) begin
      $display("gray_histogram_mode_and_unique test passed");
    end else begin
      $display("gray_histogram_mode_and_unique test failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/hgm_pkg.sv
rtl/core/hgm_bin_ram.sv
rtl/core/hgm_scan_unit.sv
rtl/core/gray_histogram_mode_and_unique.sv
rtl/core/hgm_checker.sv
tb/tb_top.sv
